/* src/crct_pkg.sv */
// crct_pkg: shared widths, nibble table and fold function for the crc16 trailer block
// no dependencies; imported by crct_fold and crc16_packet_trailer
package crct_pkg;

   localparam int REQ_DATA_W = 8;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_USER_W = 1;
   localparam int CRC_W      = 16;
   localparam int LEN_W      = 8;

   // tuser bit positions on the request side
   localparam int REQ_USER_FIRST   = 0;
   localparam int REQ_USER_ALIGNED = 1;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_BAD_LEN = 1'b1;

   localparam logic [LEN_W-1:0] MIN_LEN = 8'd2;

   typedef logic [CRC_W-1:0] crc_type;
   typedef logic [LEN_W-1:0] len_type;

   // crc-16/arc remainder of one nibble, reflected poly 0xa001
   localparam crc_type NIB_TAB [16] = '{
      16'h0000, 16'hCC01, 16'hD801, 16'h1400, 16'hF001, 16'h3C00, 16'h2800, 16'hE401,
      16'hA001, 16'h6C00, 16'h7800, 16'hB401, 16'h5000, 16'h9C01, 16'h8801, 16'h4400
   };

   function automatic crc_type fold_nibble(crc_type crc, logic [3:0] nib);
      crc_type shifted;
      shifted = {4'h0, crc[CRC_W-1:4]};
      return shifted ^ NIB_TAB[crc[3:0]] ^ NIB_TAB[nib];
   endfunction

endpackage

/* src/crct_fold.sv */
// crct_fold: folds one byte into a crc-16/arc remainder, low nibble first
// depends on crct_pkg for the nibble table
module crct_fold (
   input  crct_pkg::crc_type crc_in,
   input  logic [7:0]        byte_in,
   output crct_pkg::crc_type crc_out
);
   import crct_pkg::*;

   crc_type crc_mid;

   assign crc_mid = fold_nibble(crc_in, byte_in[3:0]);
   assign crc_out = fold_nibble(crc_mid, byte_in[7:4]);

endmodule

/* src/crc16_packet_trailer.sv */
// crc16_packet_trailer: crc-16/arc trailer value and offset for length-prefixed packets
// depends on crct_pkg and crct_fold
//
//  channel | dir | tdata (low bit up)                      | tuser (low bit up)
//  req_    | in  | data_byte[7:0]                          | first_of_packet, aligned
//  rsp_    | out | crc_value[15:0], crc_offset[7:0]        | status
//
// one byte per cycle sustained while the result register is free or taken; a byte goes
// input register -> fold/length logic -> result register, so a result is valid once the
// beat that ends the covered part has passed through both registers
// reset clears the packet state and the valid flags of both register stages
// a held result that is not taken stalls the byte in the input register, result or not
// bytes outside a packet (crc and pad bytes) are dropped and produce no result
module crc16_packet_trailer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [crct_pkg::REQ_DATA_W-1:0]   req_tdata,  // data_byte[7:0]
   input  logic [crct_pkg::REQ_USER_W-1:0]   req_tuser,  // first_of_packet, aligned
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [crct_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // crc_value[15:0], crc_offset[7:0]
   output logic [crct_pkg::RSP_USER_W-1:0]   rsp_tuser   // status
);
   import crct_pkg::*;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_first_ff;
   logic       in_aligned_ff;

   // packet state
   crc_type crc_acc_ff, crc_acc_in;
   len_type bytes_left_ff, bytes_left_in;
   len_type covered_len_ff, covered_len_in;
   logic    pad_flag_ff, pad_flag_in;
   logic    in_packet_ff, in_packet_in;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   crc_type rsp_crc_ff;
   len_type rsp_off_ff;
   logic    rsp_status_ff;

   logic    req_beat, out_free, advance;
   crc_type fold_src, fold_res;
   logic    emit, emit_err;
   crc_type emit_crc;
   len_type emit_off;
   len_type len_m2;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_beat   = req_tvalid && req_tready;

   assign fold_src = in_first_ff ? '0 : crc_acc_ff;

   crct_fold u_fold (
      .crc_in  (fold_src),
      .byte_in (in_byte_ff),
      .crc_out (fold_res)
   );

   assign len_m2 = in_byte_ff - MIN_LEN;

   always_comb begin
      crc_acc_in     = crc_acc_ff;
      bytes_left_in  = bytes_left_ff;
      covered_len_in = covered_len_ff;
      pad_flag_in    = pad_flag_ff;
      in_packet_in   = in_packet_ff;
      emit           = 1'b0;
      emit_err       = 1'b0;
      if (advance) begin
         if (in_first_ff) begin
            pad_flag_in = in_aligned_ff;
            if (in_byte_ff < MIN_LEN) begin
               crc_acc_in     = '0;
               covered_len_in = '0;
               bytes_left_in  = '0;
               in_packet_in   = 1'b0;
               emit           = 1'b1;
               emit_err       = 1'b1;
            end else if (len_m2 == '0) begin
               // nothing covered, answer at once
               crc_acc_in     = '0;
               covered_len_in = '0;
               bytes_left_in  = '0;
               in_packet_in   = 1'b0;
               emit           = 1'b1;
            end else begin
               crc_acc_in     = fold_res;
               covered_len_in = len_m2;
               bytes_left_in  = len_m2 - 8'd1;
               in_packet_in   = (len_m2 != 8'd1);
               emit           = (len_m2 == 8'd1);
            end
         end else if (in_packet_ff) begin
            crc_acc_in    = fold_res;
            bytes_left_in = (bytes_left_ff != '0) ? bytes_left_ff - 8'd1 : '0;
            if (bytes_left_in == '0) begin
               in_packet_in = 1'b0;
               emit         = 1'b1;
            end
         end
      end
   end

   // offset is the covered length, rounded up to even when padding
   assign emit_crc = emit_err ? '0 : crc_acc_in;
   assign emit_off = emit_err ? '0 : covered_len_in + {7'd0, pad_flag_in & covered_len_in[0]};

   always_comb begin
      priority if (advance) begin
         rsp_valid_in = emit;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_comb begin
      priority if (req_beat) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         crc_acc_ff     <= '0;
         bytes_left_ff  <= '0;
         covered_len_ff <= '0;
         pad_flag_ff    <= 1'b0;
         in_packet_ff   <= 1'b0;
      end else begin
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         crc_acc_ff     <= crc_acc_in;
         bytes_left_ff  <= bytes_left_in;
         covered_len_ff <= covered_len_in;
         pad_flag_ff    <= pad_flag_in;
         in_packet_ff   <= in_packet_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_byte_ff    <= req_tdata[7:0];
         in_first_ff   <= req_tuser[REQ_USER_FIRST];
         in_aligned_ff <= req_tuser[REQ_USER_ALIGNED];
      end
      if (advance && emit) begin
         rsp_crc_ff    <= emit_crc;
         rsp_off_ff    <= emit_off;
         rsp_status_ff <= emit_err ? STATUS_BAD_LEN : STATUS_OK;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_off_ff, rsp_crc_ff};
   assign rsp_tuser  = rsp_status_ff;

   a_idle_no_count : assert property (@(posedge clock) disable iff (reset)
      !in_packet_ff |-> bytes_left_ff == '0)
      else $error("bytes_left nonzero outside a packet");

   a_busy_count : assert property (@(posedge clock) disable iff (reset)
      in_packet_ff |-> (bytes_left_ff != '0) && (bytes_left_ff < covered_len_ff))
      else $error("bytes_left out of range inside a packet");

   a_err_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == STATUS_BAD_LEN) |-> rsp_tdata == '0)
      else $error("error result carries nonzero crc or offset");

   a_emit_ends_packet : assert property (@(posedge clock) disable iff (reset)
      advance && emit |=> !in_packet_ff && rsp_valid_ff)
      else $error("result issued while packet still open");

endmodule
